[rtl/sti_pkg.sv]
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the sorted table
// Table depth, field widths, command and status codes, and the structs that
// pass between the cell row and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

   localparam int DEPTH          = 16;
   localparam int VALUE_W        = 32;
   localparam int ENTRY_COUNT_W  = 5;
   localparam int CNT_W          = $clog2(DEPTH + 1);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic      insert_en;
      logic      delete_en;
      value_type value;
   } cell_op_type;

   // per-cell compare results
   typedef struct packed {
      logic greater;   // occupied and value < entry
      logic equal;     // occupied and entry == value
   } cell_flags_type;

   // row summary for the top level
   typedef struct packed {
      logic      hit;
      value_type head_next;
   } row_status_type;

endpackage

`default_nettype wire

[rtl/sti_channels.sv]
// ----------------------------------------------------------------------------
// sti_channels: request and response channel interfaces
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface sti_req_if;
   logic               valid;
   logic               ready;
   sti_pkg::cmd_type   cmd;
   sti_pkg::value_type value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sti_rsp_if;
   logic                                 valid;
   logic                                 ready;
   sti_pkg::status_type                  status;
   logic [sti_pkg::ENTRY_COUNT_W-1:0]    entry_count;
   sti_pkg::value_type                   smallest;

   modport source (output valid, output status, output entry_count, output smallest,
                   input ready);
   modport sink   (input valid, input status, input entry_count, input smallest,
                   output ready);
endinterface

`default_nettype wire

[rtl/sti_cell.sv]
// ----------------------------------------------------------------------------
// sti_cell: one slot of the sorted table
// Holds one entry; on insert takes the left neighbour or the new value, on
// delete takes the right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_cell (
   input  wire                    clock,
   input  sti_pkg::cell_op_type   op,
   input  wire                    occupied,
   input  wire                    at_tail,
   input  sti_pkg::value_type     left_entry,
   input  wire                    left_greater,
   input  sti_pkg::value_type     right_entry,
   output sti_pkg::value_type     entry,
   output sti_pkg::value_type     entry_next,
   output sti_pkg::cell_flags_type flags
);
   import sti_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      not_less;

   always_comb begin
      flags.greater = occupied && (op.value < entry_ff);
      flags.equal   = occupied && (entry_ff == op.value);
      not_less      = occupied && !(entry_ff < op.value);

      entry_in = entry_ff;
      if (op.insert_en) begin
         if (left_greater) begin
            entry_in = left_entry;            // shift right
         end else if (flags.greater || at_tail) begin
            entry_in = op.value;              // insertion point
         end
      end else if (op.delete_en && not_less) begin
         entry_in = right_entry;              // close the gap
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

[rtl/sti_cell_row.sv]
// ----------------------------------------------------------------------------
// sti_cell_row: chain of table cells
// Links neighbouring cells, derives occupancy from the count and reports
// whether the request value is present and the head entry after the update.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_cell_row (
   input  wire                     clock,
   input  sti_pkg::cell_op_type    op,
   input  sti_pkg::count_type      used,
   output sti_pkg::row_status_type status
);
   import sti_pkg::*;

   value_type      entry      [DEPTH];
   value_type      entry_next [DEPTH];
   cell_flags_type flags      [DEPTH];
   logic [DEPTH-1:0] equal_vec;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_entry;
      logic      left_greater;
      value_type right_entry;

      if (i == 0) begin : g_head
         assign left_entry   = '0;
         assign left_greater = 1'b0;
      end else begin : g_body
         assign left_entry   = entry[i-1];
         assign left_greater = flags[i-1].greater;
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      sti_cell u_cell (
         .clock        (clock),
         .op           (op),
         .occupied     (CNT_W'(i) < used),
         .at_tail      (CNT_W'(i) == used),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .entry        (entry[i]),
         .entry_next   (entry_next[i]),
         .flags        (flags[i])
      );

      assign equal_vec[i] = flags[i].equal;
   end

   assign status.hit       = |equal_vec;
   assign status.head_next = entry_next[0];

endmodule

`default_nettype wire

[rtl/sorted_table_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_delete: bounded ascending table of signed words
// Insert and delete commands on a chain of cells, one response per command.
// ----------------------------------------------------------------------------
// Usage:
//   req carries cmd (insert or delete) and a signed 32-bit value. rsp returns
//   status (done, full, not found), entry_count after the command and the
//   smallest stored entry (zero when the table is empty).
//   Every cell compares the request value with its own entry in parallel, and
//   the entries beyond the insertion or deletion point shift by one slot in
//   the cycle of the transfer, so the response is valid the cycle after the
//   request transfer. One command per cycle is sustained while the receiver
//   takes each response without stalling.
//   The response sits in an output register; req.ready stays high while that
//   register is empty or is being emptied in the same cycle. When the
//   receiver stalls, the response holds and req.ready drops, so no command
//   is lost or reordered.
//   Reset clears the entry count and the response valid; the cell contents
//   need no clearing, as only occupied slots are ever compared or reported.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_delete (
   input  wire         clock,
   input  wire         reset,
   sti_req_if.sink     req,
   sti_rsp_if.source   rsp
);
   import sti_pkg::*;

   count_type      used_ff;
   count_type      used_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   status_type     rsp_status_ff;
   status_type     rsp_status_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;
   value_type      rsp_smallest_ff;
   value_type      rsp_smallest_in;

   logic           fire;
   logic           full;
   cell_op_type    op;
   row_status_type row_status;

   // accept while the output register is free or being drained
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;
   assign full      = (used_ff == CNT_W'(DEPTH));

   sti_cell_row u_row (
      .clock  (clock),
      .op     (op),
      .used   (used_ff),
      .status (row_status)
   );

   always_comb begin
      op.value     = req.value;
      op.insert_en = fire && (req.cmd == CMD_INSERT) && !full;
      op.delete_en = fire && (req.cmd == CMD_DELETE) && row_status.hit;

      used_in = used_ff;
      if (op.insert_en) begin
         used_in = used_ff + 1'b1;
      end else if (op.delete_en) begin
         used_in = used_ff - 1'b1;
      end

      // status of this command; a refused or missed command leaves the table
      case (req.cmd)
         CMD_INSERT: rsp_status_in = full ? ST_FULL : ST_DONE;
         CMD_DELETE: rsp_status_in = row_status.hit ? ST_DONE : ST_NOT_FOUND;
         default:    rsp_status_in = ST_DONE;
      endcase

      // head of the table after the update; report zero once empty
      rsp_smallest_in = (used_in != '0) ? row_status.head_next : '0;

      // hold the response until it is taken, load on every request transfer
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_count_ff    <= ENTRY_COUNT_W'(used_in);
         rsp_smallest_ff <= rsp_smallest_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.smallest    = rsp_smallest_ff;

`ifndef SYNTHESIS
   // count never passes the table depth
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   // a stalled response blocks any table update
   a_stall_holds_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(used_ff))
      else $error("table changed while response stalled");

   // accepted insert grows the table by exactly one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      fire && (req.cmd == CMD_INSERT) && !full
      |=> (used_ff == $past(used_ff) + 1'b1) && (rsp_status_ff == ST_DONE))
      else $error("insert did not add one entry");

   // missed delete leaves the count unchanged
   a_miss_keeps: assert property (@(posedge clock) disable iff (reset)
      fire && (req.cmd == CMD_DELETE) && !row_status.hit
      |=> $stable(used_ff) && (rsp_status_ff == ST_NOT_FOUND))
      else $error("missed delete changed the table");
`endif

endmodule

`default_nettype wire
